// ===== rtl/line_follower_mode_sequencer_defines.svh =====
// Assertion macros for the line follower mode sequencer.
`ifndef LINE_FOLLOWER_MODE_SEQUENCER_DEFINES_SVH
`define LINE_FOLLOWER_MODE_SEQUENCER_DEFINES_SVH
`ifndef ASSERT_OFF
`define LFMS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define LFMS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define LFMS_ASSERT(label, clk, rst_n, prop, msg)
`define LFMS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== rtl/lfms_pkg.sv =====
package lfms_pkg;

  localparam int TIME_BITS_DEF  = 32;
  localparam int ERROR_BITS_DEF = 11;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int SPEED_W     = 8;
  localparam int THRESH_W    = 10;
  localparam int SPIN_W      = 9;

  localparam logic [CFG_INDEX_W-1:0] CFG_SEARCH_SPEED     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PIVOT_SPEED      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CORNER_THRESHOLD = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIDE_THRESHOLD   = 3'd3;

  localparam logic [SPEED_W-1:0]  SEARCH_SPEED_RST     = 8'd125;
  localparam logic [SPEED_W-1:0]  PIVOT_SPEED_RST      = 8'd125;
  localparam logic [THRESH_W-1:0] CORNER_THRESHOLD_RST = 10'd588;
  localparam logic [THRESH_W-1:0] SIDE_THRESHOLD_RST   = 10'd179;

  localparam logic [2:0] MODE_FOLLOW = 3'd0;
  localparam logic [2:0] MODE_LOST   = 3'd1;
  localparam logic [2:0] MODE_TURN   = 3'd2;
  localparam logic [2:0] MODE_CROSS  = 3'd3;
  localparam logic [2:0] MODE_END    = 3'd4;
  localparam logic [2:0] MODE_GAP    = 3'd5;

  localparam logic [1:0] SIDE_CENTER = 2'd0;
  localparam logic [1:0] SIDE_LEFT   = 2'd1;
  localparam logic [1:0] SIDE_RIGHT  = 2'd2;

  localparam logic [1:0] ACT_STEER = 2'd0;
  localparam logic [1:0] ACT_SPIN  = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;

  localparam int TURN_MIN_MS    = 300;
  localparam int TURN_MAX_MS    = 600;
  localparam int HOLDOFF_MS     = 150;
  localparam int END_CONFIRM_MS = 190;
  localparam int GAP_CENTER_MS  = 180;
  localparam int GAP_SIDE_MS    = 120;
  localparam int RECENT_MS      = 400;

endpackage

// ===== rtl/lfms_if.sv =====
interface lfms_in_if #(
  parameter int TIME_BITS  = lfms_pkg::TIME_BITS_DEF,
  parameter int ERROR_BITS = lfms_pkg::ERROR_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [TIME_BITS-1:0]         now_ms;
  logic signed [ERROR_BITS-1:0] position_error;
  logic                         line_lost;
  logic                         junction;

  modport source(output valid, now_ms, position_error, line_lost, junction, input ready);
  modport sink(input valid, now_ms, position_error, line_lost, junction, output ready);
endinterface

interface lfms_out_if #(
  parameter int ERROR_BITS = lfms_pkg::ERROR_BITS_DEF
);
  logic                                 valid;
  logic                                 ready;
  logic [2:0]                           mode_code;
  logic [1:0]                           drive_action;
  logic signed [lfms_pkg::SPIN_W-1:0]   spin_speed;
  logic signed [ERROR_BITS-1:0]         steer_error;
  logic                                 led_on;

  modport source(output valid, mode_code, drive_action, spin_speed, steer_error, led_on,
                 input ready);
  modport sink(input valid, mode_code, drive_action, spin_speed, steer_error, led_on,
               output ready);
endinterface

interface lfms_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [lfms_pkg::CFG_INDEX_W-1:0] index;
  logic [lfms_pkg::CFG_DATA_W-1:0]  data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/line_follower_mode_sequencer.sv =====
// Line follower mode sequencer. Each input transaction is one control tick carrying the
// millisecond time, the signed line position error and the line-lost and junction flags;
// each produces exactly one result transaction with the mode, the drive command, the spin
// speed, the steering error and the end-point lamp. The block takes one transaction per
// clock cycle while results are taken. A tick is held in the input register until the result
// register is free or its result is taken; its result is then offered from the result register.
// When a result waits, a full input register holds and the input is blocked. The mode state
// advances once per tick. Configuration writes are always accepted and must only be issued
// while no tick is in flight. Time differences wrap modulo two to the power of TIME_BITS.
`include "line_follower_mode_sequencer_defines.svh"

module line_follower_mode_sequencer #(
  parameter int TIME_BITS  = lfms_pkg::TIME_BITS_DEF,
  parameter int ERROR_BITS = lfms_pkg::ERROR_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  lfms_in_if.sink   in_ch,
  lfms_out_if.source out_ch,
  lfms_cfg_if.sink  cfg_ch
);
  import lfms_pkg::*;

  localparam int SW = ((ERROR_BITS > THRESH_W) ? ERROR_BITS : THRESH_W) + 2;

  logic                         s1_vld_r;
  logic [TIME_BITS-1:0]         s1_now_r;
  logic signed [ERROR_BITS-1:0] s1_err_r;
  logic                         s1_lost_r;
  logic                         s1_junc_r;
  logic                         s1_adv;

  logic                         out_vld_r;
  logic [2:0]                   out_mode_r;
  logic [1:0]                   out_act_r;
  logic signed [SPIN_W-1:0]     out_spin_r;
  logic signed [ERROR_BITS-1:0] out_steer_r;
  logic                         out_led_r;

  logic [SPEED_W-1:0]  search_speed_r;
  logic [SPEED_W-1:0]  pivot_speed_r;
  logic [THRESH_W-1:0] corner_thr_r;
  logic [THRESH_W-1:0] side_thr_r;

  logic [2:0]           mode_r, mode_nxt;
  logic [2:0]           prior_r, prior_nxt;
  logic [1:0]           side_r, side_nxt;
  logic [TIME_BITS-1:0] holdoff_r, holdoff_nxt;
  logic [TIME_BITS-1:0] turn_r, turn_nxt;
  logic [TIME_BITS-1:0] endpt_r, endpt_nxt;
  logic [TIME_BITS-1:0] lost_r, lost_nxt;

  logic signed [SW-1:0]  err_ext;
  logic signed [SW-1:0]  side_thr_ext;
  logic [SW-1:0]         err_mag;
  logic [SW-1:0]         corner_thr_ext;
  logic [TIME_BITS-1:0]  el_turn, el_hold, el_end, el_lost;
  logic [TIME_BITS-1:0]  gap_limit;
  logic [1:0]            side_upd;

  logic [1:0]               act_nxt;
  logic signed [SPIN_W-1:0] spin_nxt;
  logic signed [ERROR_BITS-1:0] steer_nxt;
  logic                     led_nxt;

  assign s1_adv       = s1_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !s1_vld_r || s1_adv;
  assign cfg_ch.ready = 1'b1;

  assign err_ext        = SW'(s1_err_r);
  assign side_thr_ext   = $signed({{(SW-THRESH_W){1'b0}}, side_thr_r});
  assign corner_thr_ext = {{(SW-THRESH_W){1'b0}}, corner_thr_r};
  assign err_mag        = (err_ext < 0) ? $unsigned(-err_ext) : $unsigned(err_ext);

  assign el_turn = s1_now_r - turn_r;
  assign el_hold = s1_now_r - holdoff_r;
  assign el_end  = s1_now_r - endpt_r;
  assign el_lost = s1_now_r - lost_r;

  always_comb begin
    side_upd = side_r;
    if (!s1_lost_r) begin
      if (err_ext < -side_thr_ext) begin
        side_upd = SIDE_LEFT;
      end else if (err_ext > side_thr_ext) begin
        side_upd = SIDE_RIGHT;
      end else begin
        side_upd = SIDE_CENTER;
      end
    end
  end

  assign gap_limit = (side_upd == SIDE_CENTER) ? TIME_BITS'(GAP_CENTER_MS)
                                               : TIME_BITS'(GAP_SIDE_MS);

  always_comb begin
    mode_nxt    = mode_r;
    prior_nxt   = prior_r;
    side_nxt    = side_upd;
    holdoff_nxt = holdoff_r;
    turn_nxt    = turn_r;
    endpt_nxt   = endpt_r;
    lost_nxt    = lost_r;
    if (mode_r == MODE_TURN) begin
      if (el_turn >= TIME_BITS'(TURN_MIN_MS)) begin
        if (s1_lost_r) begin
          if (el_turn > TIME_BITS'(TURN_MAX_MS)) begin
            mode_nxt = MODE_LOST;
          end
        end else begin
          mode_nxt    = MODE_FOLLOW;
          holdoff_nxt = s1_now_r;
        end
      end
    end else begin
      if (s1_junc_r) begin
        if (el_hold > TIME_BITS'(HOLDOFF_MS)) begin
          if (err_mag > corner_thr_ext) begin
            mode_nxt = MODE_TURN;
            turn_nxt = s1_now_r;
          end else if (mode_r != MODE_CROSS && mode_r != MODE_END) begin
            endpt_nxt = s1_now_r;
            mode_nxt  = MODE_CROSS;
            side_nxt  = SIDE_CENTER;
          end else if (mode_r == MODE_CROSS && el_end > TIME_BITS'(END_CONFIRM_MS)) begin
            mode_nxt = MODE_END;
          end
        end
      end else if (s1_lost_r) begin
        if (mode_r != MODE_GAP && mode_r != MODE_LOST) begin
          mode_nxt = MODE_GAP;
          lost_nxt = s1_now_r;
        end else if (mode_r == MODE_GAP && el_lost > gap_limit) begin
          if (el_hold < TIME_BITS'(RECENT_MS) && side_upd != SIDE_CENTER) begin
            mode_nxt    = MODE_TURN;
            turn_nxt    = s1_now_r;
            holdoff_nxt = '0;
          end else begin
            mode_nxt = MODE_LOST;
          end
        end
      end else if (mode_r != MODE_CROSS && mode_r != MODE_END) begin
        mode_nxt = MODE_FOLLOW;
      end
      if (prior_r == MODE_CROSS && mode_nxt != MODE_CROSS && mode_nxt != MODE_END) begin
        holdoff_nxt = s1_now_r;
      end
      prior_nxt = mode_nxt;
    end
  end

  always_comb begin
    act_nxt   = ACT_STEER;
    spin_nxt  = '0;
    steer_nxt = '0;
    led_nxt   = 1'b0;
    case (mode_nxt)
      MODE_FOLLOW: begin
        steer_nxt = s1_err_r;
      end
      MODE_LOST: begin
        act_nxt  = ACT_SPIN;
        spin_nxt = (side_nxt == SIDE_LEFT) ? -$signed({1'b0, search_speed_r})
                                           : $signed({1'b0, search_speed_r});
      end
      MODE_TURN: begin
        if (side_nxt == SIDE_LEFT) begin
          act_nxt  = ACT_SPIN;
          spin_nxt = -$signed({1'b0, pivot_speed_r});
        end else if (side_nxt == SIDE_RIGHT) begin
          act_nxt  = ACT_SPIN;
          spin_nxt = $signed({1'b0, pivot_speed_r});
        end
      end
      MODE_END: begin
        act_nxt = ACT_STOP;
        led_nxt = 1'b1;
      end
      MODE_CROSS, MODE_GAP: begin
        act_nxt = ACT_STEER;
      end
      default: begin
        act_nxt = ACT_STOP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_speed_r <= SEARCH_SPEED_RST;
      pivot_speed_r  <= PIVOT_SPEED_RST;
      corner_thr_r   <= CORNER_THRESHOLD_RST;
      side_thr_r     <= SIDE_THRESHOLD_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_SEARCH_SPEED:     search_speed_r <= cfg_ch.data[SPEED_W-1:0];
        CFG_PIVOT_SPEED:      pivot_speed_r  <= cfg_ch.data[SPEED_W-1:0];
        CFG_CORNER_THRESHOLD: corner_thr_r   <= cfg_ch.data[THRESH_W-1:0];
        CFG_SIDE_THRESHOLD:   side_thr_r     <= cfg_ch.data[THRESH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_now_r  <= in_ch.now_ms;
      s1_err_r  <= in_ch.position_error;
      s1_lost_r <= in_ch.line_lost;
      s1_junc_r <= in_ch.junction;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_FOLLOW;
      prior_r   <= MODE_FOLLOW;
      side_r    <= SIDE_CENTER;
      holdoff_r <= '0;
      turn_r    <= '0;
      endpt_r   <= '0;
      lost_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        mode_r    <= mode_nxt;
        prior_r   <= prior_nxt;
        side_r    <= side_nxt;
        holdoff_r <= holdoff_nxt;
        turn_r    <= turn_nxt;
        endpt_r   <= endpt_nxt;
        lost_r    <= lost_nxt;
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_mode_r  <= mode_nxt;
      out_act_r   <= act_nxt;
      out_spin_r  <= spin_nxt;
      out_steer_r <= steer_nxt;
      out_led_r   <= led_nxt;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.mode_code    = out_mode_r;
  assign out_ch.drive_action = out_act_r;
  assign out_ch.spin_speed   = out_spin_r;
  assign out_ch.steer_error  = out_steer_r;
  assign out_ch.led_on       = out_led_r;

  `LFMS_ASSERT(a_full_stall, clk, rst_n, (s1_vld_r && out_vld_r && !out_ch.ready) |-> !in_ch.ready, "Input accepted while both stages are stalled.")
  `LFMS_ASSERT_NEXT(a_accept_loads, clk, rst_n, in_ch.valid && in_ch.ready, s1_vld_r, "Accepted transaction did not enter the input register.")
  `LFMS_ASSERT(a_spin_only, clk, rst_n, (out_vld_r && out_act_r != ACT_SPIN) |-> (out_spin_r == 0), "Nonzero spin speed without a spin command.")
  `LFMS_ASSERT(a_lamp_stop, clk, rst_n, (out_vld_r && out_led_r) |-> (out_act_r == ACT_STOP && out_mode_r == MODE_END), "End-point lamp outside end point mode.")

endmodule
